### design/bpt_pkg.sv
// Shared types, codes and constants of the breakpoint table.
package bpt_pkg;

  localparam int AddrW   = 24;
  localparam int WordW   = 16;
  localparam int ModeW   = 4;
  localparam int SlotW   = 8;
  localparam int HitW    = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 24;

  localparam int NumBreaksDef = 8;
  localparam int AddrBitsDef  = 24;

  localparam logic [AddrW-1:0] FixedFloor = 24'h001000;
  localparam logic [AddrW-1:0] FixedWrap  = 24'h3FFFFF;
  localparam logic [AddrW-1:0] FixedCeil  = 24'h3F8000;

  localparam logic [AddrW-1:0] MaskReset   = 24'hFFFFFF;
  localparam logic [AddrW-1:0] LowerReset  = 24'h001000;
  localparam logic [AddrW-1:0] UpperReset  = 24'h3F8000;
  localparam logic [WordW-1:0] OpcodeReset = 16'h4AFC;

  typedef enum logic [ModeW-1:0] {
    MODE_CREATE    = 4'd0,
    MODE_ENABLE    = 4'd1,
    MODE_DISABLE   = 4'd2,
    MODE_CLEAR_ONE = 4'd3,
    MODE_CLEAR_ALL = 4'd4,
    MODE_CHECK_PC  = 4'd5,
    MODE_SET_STEP  = 4'd6,
    MODE_INSTALL   = 4'd7,
    MODE_REMOVE    = 4'd8
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ADDR_MASK   = 2'd0,
    CFG_LOWER_LIMIT = 2'd1,
    CFG_UPPER_LIMIT = 2'd2,
    CFG_BREAK_OP    = 2'd3
  } cfg_e;

  // Reasons a create address is refused before the table is consulted.
  typedef struct packed {
    logic odd;
    logic below_lower;
    logic not_below_upper;
    logic below_floor;
    logic in_top_region;
  } rule_t;

endpackage

### design/bpt_rule_chk.sv
// Address masking and create-address range rules of the breakpoint table.
module bpt_rule_chk import bpt_pkg::*; #(
  parameter int ADDR_BITS = AddrBitsDef
) (
  input  logic [AddrW-1:0] address_i,
  input  logic [AddrW-1:0] mask_i,
  input  logic [AddrW-1:0] lower_i,
  input  logic [AddrW-1:0] upper_i,
  output logic [AddrW-1:0] key_o,
  output logic [AddrW-1:0] cut_o,
  output rule_t            rule_o
);

  localparam int CutBits = (ADDR_BITS < AddrW) ? ADDR_BITS : AddrW;
  localparam logic [AddrW-1:0] CutMask = {AddrW{1'b1}} >> (AddrW - CutBits);

  assign cut_o = address_i & CutMask;
  assign key_o = address_i & mask_i & CutMask;

  always_comb begin
    rule_o.odd             = key_o[0];
    rule_o.below_lower     = key_o < lower_i;
    rule_o.not_below_upper = key_o >= upper_i;
    rule_o.below_floor     = key_o < FixedFloor;
    rule_o.in_top_region   = (key_o & FixedWrap) >= FixedCeil;
  end

endmodule

### design/breakpoint_table_unit.sv
// Breakpoint table: slot store, command sequencer with one shared address compare.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o  mode, address, slot, saved_word
//   out      output     out_valid_o / out_ready_i status, hit, hit_slot, write_*, last
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// Create and check pc step through the user slots one per cycle with a single address
// comparator fed by the registered read port of the slot store.
// Install and remove visit all NUM_BREAKS + 1 slots, one result per enabled slot, and
// give one closing result when no slot is enabled.
// Reset clears the used and enabled marks at once. A full output register stalls the walk
// and the closing result; the input is taken only between commands.
module breakpoint_table_unit import bpt_pkg::*; #(
  parameter int NUM_BREAKS = NumBreaksDef,
  parameter int ADDR_BITS  = AddrBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [AddrW-1:0]   address_i,
  input  logic [SlotW-1:0]   slot_i,
  input  logic [WordW-1:0]   saved_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic               hit_o,
  output logic [HitW-1:0]    hit_slot_o,
  output logic               write_valid_o,
  output logic [AddrW-1:0]   write_address_o,
  output logic [WordW-1:0]   write_data_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int NumSlots = NUM_BREAKS + 1;
  localparam int IdxW     = $clog2(NumSlots);
  localparam logic [IdxW-1:0] StepIdx  = IdxW'(NUM_BREAKS);
  localparam logic [IdxW-1:0] LastUser = IdxW'(NUM_BREAKS - 1);
  localparam logic [NumSlots-1:0] StepBit = NumSlots'(1) << NUM_BREAKS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_FIN
  } state_e;

  // Configuration registers.
  logic [AddrW-1:0] mask_q, lower_q, upper_q;
  logic [WordW-1:0] opcode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= MaskReset;
      lower_q  <= LowerReset;
      upper_q  <= UpperReset;
      opcode_q <= OpcodeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ADDR_MASK:   mask_q   <= cfg_wdata_i[AddrW-1:0];
        CFG_LOWER_LIMIT: lower_q  <= cfg_wdata_i[AddrW-1:0];
        CFG_UPPER_LIMIT: upper_q  <= cfg_wdata_i[AddrW-1:0];
        CFG_BREAK_OP:    opcode_q <= cfg_wdata_i[WordW-1:0];
        default: ;
      endcase
    end
  end

  logic [AddrW-1:0] key_create, key_cut;
  rule_t            rule;

  bpt_rule_chk #(
    .ADDR_BITS (ADDR_BITS)
  ) u_rule_chk (
    .address_i (address_i),
    .mask_i    (mask_q),
    .lower_i   (lower_q),
    .upper_i   (upper_q),
    .key_o     (key_create),
    .cut_o     (key_cut),
    .rule_o    (rule)
  );

  state_e               state_q, state_d;
  logic [ModeW-1:0]     mode_q, mode_d;
  logic [AddrW-1:0]     key_q, key_d;
  logic [WordW-1:0]     word_q, word_d;
  logic [SlotW-1:0]     slot_q, slot_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [IdxW-1:0]      sel_q, sel_d;
  logic                 bad_q, bad_d;
  logic                 found_q, found_d;
  logic                 free_ok_q, free_ok_d;
  logic                 any_q, any_d;
  logic [NumSlots-1:0]  used_q, used_d;
  logic [NumSlots-1:0]  enabled_q, enabled_d;

  logic                 out_valid_q, out_valid_d;
  logic                 status_q, status_d;
  logic                 hit_q, hit_d;
  logic [HitW-1:0]      hit_slot_q, hit_slot_d;
  logic                 wv_q, wv_d;
  logic [AddrW-1:0]     wa_q, wa_d;
  logic [WordW-1:0]     wd_q, wd_d;
  logic                 last_q, last_d;

  // Slot store: one write port, one registered read port addressed by the next index.
  logic [AddrW-1:0]     addr_mem [NumSlots];
  logic [WordW-1:0]     word_mem [NumSlots];
  logic [AddrW-1:0]     rd_addr_q;
  logic [WordW-1:0]     rd_word_q;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_wa;
  logic [AddrW-1:0]     mem_wad;
  logic [WordW-1:0]     mem_wwd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      addr_mem[mem_wa] <= mem_wad;
      word_mem[mem_wa] <= mem_wwd;
    end
    rd_addr_q <= addr_mem[idx_d];
    rd_word_q <= word_mem[idx_d];
  end

  logic                 can_push, push, match, later_en, slot_ok, reject;
  logic [IdxW-1:0]      si;

  assign can_push = !out_valid_q || out_ready_i;
  assign match    = rd_addr_q == key_q;
  assign slot_ok  = slot_q < SlotW'(NUM_BREAKS);
  assign si       = slot_q[IdxW-1:0];
  assign reject   = bad_q || found_q || !free_ok_q;

  always_comb begin
    later_en = 1'b0;
    for (int j = 0; j < NumSlots; j++) begin
      if (enabled_q[j] && (IdxW'(j) > idx_q)) begin
        later_en = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    word_d      = word_q;
    slot_d      = slot_q;
    idx_d       = idx_q;
    sel_d       = sel_q;
    bad_d       = bad_q;
    found_d     = found_q;
    free_ok_d   = free_ok_q;
    any_d       = any_q;
    used_d      = used_q;
    enabled_d   = enabled_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    wv_d        = wv_q;
    wa_d        = wa_q;
    wd_d        = wd_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_wa      = StepIdx;
    mem_wad     = key_q;
    mem_wwd     = word_q;
    push        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d    = mode_i;
          key_d     = (mode_i == MODE_CREATE) ? key_create : key_cut;
          word_d    = saved_word_i;
          slot_d    = slot_i;
          idx_d     = '0;
          sel_d     = '0;
          bad_d     = |rule;
          found_d   = 1'b0;
          free_ok_d = 1'b0;
          any_d     = 1'b0;
          case (mode_i)
            MODE_CREATE, MODE_CHECK_PC: state_d = S_SCAN;
            MODE_INSTALL, MODE_REMOVE:  state_d = S_WALK;
            default:                    state_d = S_FIN;
          endcase
        end
      end

      S_SCAN: begin
        if (mode_q == MODE_CREATE) begin
          if (used_q[idx_q] && match) begin
            found_d = 1'b1;
          end
          if (!used_q[idx_q] && !free_ok_q) begin
            free_ok_d = 1'b1;
            sel_d     = idx_q;
          end
        end else if (enabled_q[idx_q] && match && !found_q) begin
          found_d = 1'b1;
          sel_d   = idx_q;
        end
        if (idx_q == LastUser) begin
          state_d = S_FIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_WALK: begin
        if (!enabled_q[idx_q] || can_push) begin
          if (enabled_q[idx_q]) begin
            push       = 1'b1;
            any_d      = 1'b1;
            status_d   = 1'b0;
            hit_d      = 1'b0;
            hit_slot_d = '0;
            wv_d       = 1'b1;
            wa_d       = rd_addr_q;
            wd_d       = (mode_q == MODE_INSTALL) ? opcode_q : rd_word_q;
            last_d     = !later_en;
          end
          if (idx_q == StepIdx) begin
            if (mode_q == MODE_REMOVE) begin
              used_d[NUM_BREAKS]    = 1'b0;
              enabled_d[NUM_BREAKS] = 1'b0;
            end
            // An empty walk still owes one closing result.
            state_d = (any_q || push) ? S_IDLE : S_FIN;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      S_FIN: begin
        if (can_push) begin
          push       = 1'b1;
          state_d    = S_IDLE;
          status_d   = 1'b0;
          hit_d      = 1'b0;
          hit_slot_d = '0;
          wv_d       = 1'b0;
          wa_d       = '0;
          wd_d       = '0;
          last_d     = 1'b1;
          case (mode_q)
            MODE_CREATE: begin
              status_d = reject;
              if (!reject) begin
                mem_we            = 1'b1;
                mem_wa            = sel_q;
                used_d[sel_q]     = 1'b1;
                enabled_d[sel_q]  = 1'b1;
              end
            end
            MODE_ENABLE, MODE_DISABLE: begin
              if (slot_ok && used_q[si]) begin
                enabled_d[si] = (mode_q == MODE_ENABLE);
              end else begin
                status_d = 1'b1;
              end
            end
            MODE_CLEAR_ONE: begin
              if (slot_ok) begin
                used_d[si]    = 1'b0;
                enabled_d[si] = 1'b0;
              end else begin
                status_d = 1'b1;
              end
            end
            MODE_CLEAR_ALL: begin
              used_d    = used_q & StepBit;
              enabled_d = enabled_q & StepBit;
            end
            MODE_CHECK_PC: begin
              hit_d      = found_q;
              hit_slot_d = found_q ? HitW'(sel_q) : '0;
            end
            MODE_SET_STEP: begin
              mem_we                = 1'b1;
              mem_wa                = StepIdx;
              used_d[NUM_BREAKS]    = 1'b1;
              enabled_d[NUM_BREAKS] = 1'b1;
            end
            MODE_INSTALL, MODE_REMOVE: ;
            default: status_d = 1'b1;
          endcase
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (push) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= '0;
      key_q       <= '0;
      word_q      <= '0;
      slot_q      <= '0;
      idx_q       <= '0;
      sel_q       <= '0;
      bad_q       <= 1'b0;
      found_q     <= 1'b0;
      free_ok_q   <= 1'b0;
      any_q       <= 1'b0;
      used_q      <= '0;
      enabled_q   <= '0;
      out_valid_q <= 1'b0;
      status_q    <= 1'b0;
      hit_q       <= 1'b0;
      hit_slot_q  <= '0;
      wv_q        <= 1'b0;
      wa_q        <= '0;
      wd_q        <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      key_q       <= key_d;
      word_q      <= word_d;
      slot_q      <= slot_d;
      idx_q       <= idx_d;
      sel_q       <= sel_d;
      bad_q       <= bad_d;
      found_q     <= found_d;
      free_ok_q   <= free_ok_d;
      any_q       <= any_d;
      used_q      <= used_d;
      enabled_q   <= enabled_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      hit_q       <= hit_d;
      hit_slot_q  <= hit_slot_d;
      wv_q        <= wv_d;
      wa_q        <= wa_d;
      wd_q        <= wd_d;
      last_q      <= last_d;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign hit_o           = hit_q;
  assign hit_slot_o      = hit_slot_q;
  assign write_valid_o   = wv_q;
  assign write_address_o = wa_q;
  assign write_data_o    = wd_q;
  assign last_o          = last_q;

  // A slot can only be enabled while it is in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (enabled_q & ~used_q) == '0)
    else $error("enabled slot without used mark");

  // The slot index never runs past the step slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) idx_q <= StepIdx)
    else $error("slot index out of range");

  // The closing result of a command returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_FIN && push) |=> state_q == S_IDLE)
    else $error("sequencer busy after closing result");

  // Table writes happen only when a command completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_we |-> (state_q == S_FIN && push))
    else $error("slot store written outside command completion");

endmodule
